### sv/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync word / length prefixed deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

	// register reset values
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hBE;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hEF;

	// deframer phase
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_FIRST   = 2'd1,
		PH_LENGTH  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	// sync word setting
	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
	} sync_cfg_t;

	// one result word
	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] byte_index;
		logic              is_last;
		logic              is_empty;
	} result_t;

endpackage

### sv/sld_if.sv
// ----------------------------------------------------------------------------
// sld_if
// Valid/ready channels of the deframer: received bytes and result words.
// ----------------------------------------------------------------------------

// received byte channel
interface sld_byte_if import sld_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// result word channel
interface sld_result_if import sld_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] byte_index;
	logic              is_last;
	logic              is_empty;

	modport source (output valid, output payload_byte, output byte_index,
		output is_last, output is_empty, input ready);
	modport sink   (input valid, input payload_byte, input byte_index,
		input is_last, input is_empty, output ready);
endinterface

### sv/sld_frame_fsm.sv
// ----------------------------------------------------------------------------
// sld_frame_fsm
// Sync hunt, length capture and payload count. Decodes one byte per step
// and updates phase, remaining count and next index on the step edge.
// ----------------------------------------------------------------------------
module sld_frame_fsm import sld_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data,
	input  sync_cfg_t         cfg,
	output logic              emit,
	output result_t           result
);

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] left_q, left_d;
	logic [BYTE_W-1:0] index_q, index_d;
	logic              last_byte;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			left_q  <= '0;
			index_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			index_q <= index_d;
		end
	end

	// a count of one or zero ends the message
	assign last_byte = (left_q <= BYTE_W'(1));

	// next state and result
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		index_d = index_q;
		emit    = 1'b0;
		result  = '{payload_byte: data, byte_index: index_q,
			is_last: 1'b0, is_empty: 1'b0};
		case (phase_q)
			PH_HUNT: begin
				if (data == cfg.sync_first)
					phase_d = PH_FIRST;
			end
			PH_FIRST: begin
				// second byte wins when both sync bytes are equal
				if (data == cfg.sync_second)
					phase_d = PH_LENGTH;
				else if (data == cfg.sync_first)
					phase_d = PH_FIRST;
				else
					phase_d = PH_HUNT;
			end
			PH_LENGTH: begin
				index_d = '0;
				if (data == '0) begin
					// zero-length message
					emit    = 1'b1;
					result  = '{payload_byte: '0, byte_index: '0,
						is_last: 1'b1, is_empty: 1'b1};
					phase_d = PH_HUNT;
					left_d  = '0;
				end else begin
					left_d  = data;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				emit           = 1'b1;
				result.is_last = last_byte;
				if (last_byte) begin
					phase_d = PH_HUNT;
					left_d  = '0;
					index_d = '0;
				end else begin
					left_d  = left_q - BYTE_W'(1);
					index_d = index_q + BYTE_W'(1);
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

endmodule

### sv/sync_length_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_deframer_unit
// Finds a two-byte sync word in a byte stream, reads the length byte and
// passes out the payload bytes with index and last mark, or an empty word for a zero length.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  rx       in   valid/ready    rx_byte
//  tx       out  valid/ready    payload_byte, byte_index, is_last, is_empty
//  cfg      in   cfg_we         cfg_index, cfg_wdata (sync_first, sync_second)
//
//  one byte per cycle sustained while tx is not stalled; a result passes
//  through the input register, then the result register
//  arst_n clears the phase, counters and both valid flags; sync bytes
//  return to 0xBE 0xEF
//  a stalled result holds the byte in the input register; bytes that give
//  no result still drain while the result waits
// ----------------------------------------------------------------------------
module sync_length_deframer_unit import sld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	sld_byte_if.sink             rx,
	sld_result_if.source         tx
);

	sync_cfg_t         cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              emit;
	result_t           result;
	logic              tx_valid_q;
	result_t           tx_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata;
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// byte leaves the input register unless its result would overrun tx
	assign advance  = valid_s1 && (!emit || !tx_valid_q || tx.ready);
	assign rx.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx.ready)
			valid_s1 <= rx.valid;
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	// framing state
	sld_frame_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.cfg    (cfg_q),
		.emit   (emit),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tx_valid_q <= 1'b0;
		else if (advance && emit)
			tx_valid_q <= 1'b1;
		else if (tx.ready)
			tx_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			tx_data_q <= result;
	end

	assign tx.valid        = tx_valid_q;
	assign tx.payload_byte = tx_data_q.payload_byte;
	assign tx.byte_index   = tx_data_q.byte_index;
	assign tx.is_last      = tx_data_q.is_last;
	assign tx.is_empty     = tx_data_q.is_empty;

endmodule

### sv/sld_checker.sv
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sld_checker import sld_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rx_ready,
	input logic              tx_valid,
	input logic              tx_ready,
	input logic [BYTE_W-1:0] tx_payload_byte,
	input logic [BYTE_W-1:0] tx_byte_index,
	input logic              tx_is_last,
	input logic              tx_is_empty
);

	// a stalled result word holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_payload_byte)
		&& $stable(tx_byte_index) && $stable(tx_is_last) && $stable(tx_is_empty))
		else $error("result word changed while stalled");

	// an empty message is a lone last word with zero fields
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_is_empty |-> tx_is_last && tx_payload_byte == '0
		&& tx_byte_index == '0)
		else $error("empty message word malformed");

	// index 254 is the last byte of the longest payload
	a_max_index_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_byte_index == BYTE_W'(254) |-> tx_is_last)
		else $error("payload ran past 255 bytes");

	// with the result register empty a byte is always taken
	a_rx_open: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_valid |-> rx_ready)
		else $error("input stalled with no result pending");

endmodule

bind sync_length_deframer_unit sld_checker u_sld_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_ready        (rx.ready),
	.tx_valid        (tx.valid),
	.tx_ready        (tx.ready),
	.tx_payload_byte (tx.payload_byte),
	.tx_byte_index   (tx.byte_index),
	.tx_is_last      (tx.is_last),
	.tx_is_empty     (tx.is_empty)
);
